### hw/rtl/gcdb_pkg.sv
// ----------------------------------------------------------------------------
// gcdb_pkg
// shared types, constants and the cordic arctangent table for the
// great-circle distance and bearing unit
// ----------------------------------------------------------------------------
package gcdb_pkg;

   typedef logic signed [31:0] q30_type;
   typedef logic [31:0]        bam_type;

   localparam int ATAN_LEN   = 40;
   localparam int SQRT_STEPS = 31;

   localparam logic [30:0] DEG_TO_BAM = 31'd1281023894;
   localparam logic [33:0] INV_GAIN   = 34'd652032874;
   localparam logic [17:0] DIST_HI    = 18'd156367;
   localparam logic [15:0] DIST_LO    = 16'd56728;
   localparam logic [15:0] CDEG_TURN  = 16'd36000;

   // binary-angle arctangent of 2^-idx
   function automatic logic [31:0] atan_tab(input int idx);
      logic [31:0] v;
      case (idx)
         0:  v = 32'h20000000;
         1:  v = 32'h12E4051E;
         2:  v = 32'h09FB385B;
         3:  v = 32'h051111D4;
         4:  v = 32'h028B0D43;
         5:  v = 32'h0145D7E1;
         6:  v = 32'h00A2F61E;
         7:  v = 32'h00517C55;
         8:  v = 32'h0028BE53;
         9:  v = 32'h00145F2F;
         10: v = 32'h000A2F98;
         11: v = 32'h000517CC;
         12: v = 32'h00028BE6;
         13: v = 32'h000145F3;
         14: v = 32'h0000A2FA;
         15: v = 32'h0000517D;
         16: v = 32'h000028BE;
         17: v = 32'h0000145F;
         18: v = 32'h00000A30;
         19: v = 32'h00000518;
         20: v = 32'h0000028C;
         21: v = 32'h00000146;
         22: v = 32'h000000A3;
         23: v = 32'h00000051;
         24: v = 32'h00000029;
         25: v = 32'h00000014;
         26: v = 32'h0000000A;
         27: v = 32'h00000005;
         28: v = 32'h00000003;
         29: v = 32'h00000001;
         30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

### hw/rtl/gcdb_delay.sv
// ----------------------------------------------------------------------------
// gcdb_delay
// enabled shift line that keeps side data aligned with the pipeline
// ----------------------------------------------------------------------------
module gcdb_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] tap_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d;
         for (int k = 1; k < DEPTH; k++) begin
            tap_ff[k] <= tap_ff[k-1];
         end
      end
   end

   assign q = tap_ff[DEPTH-1];

endmodule

### hw/rtl/gcdb_sincos.sv
// ----------------------------------------------------------------------------
// gcdb_sincos
// pipelined cordic rotation, one iteration per stage, q30 sine and cosine
// of a 32-bit binary angle
// ----------------------------------------------------------------------------
module gcdb_sincos #(
   parameter int STEPS = 24
) (
   input  logic              clock,
   input  logic              en,
   input  gcdb_pkg::bam_type ang,
   output gcdb_pkg::q30_type sin_out,
   output gcdb_pkg::q30_type cos_out
);

   localparam int W = 34;
   localparam logic signed [W-1:0] QTR  = 34'sd1073741824;
   localparam logic signed [W-1:0] HALF = 34'sd2147483648;

   logic signed [W-1:0] x_ff [0:STEPS];
   logic signed [W-1:0] y_ff [0:STEPS];
   logic signed [W-1:0] z_ff [0:STEPS];
   logic                neg_ff [0:STEPS];

   logic signed [W-1:0] z_raw;
   logic signed [W-1:0] z_in;
   logic                neg_in;

   // fold to +-90 deg
   always_comb begin
      z_raw = W'(signed'(ang));
      z_in  = z_raw;
      neg_in = 1'b0;
      if (z_raw > QTR) begin
         z_in   = z_raw - HALF;
         neg_in = 1'b1;
      end else if (z_raw < -QTR) begin
         z_in   = z_raw + HALF;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= signed'(gcdb_pkg::INV_GAIN);
         y_ff[0]   <= '0;
         z_ff[0]   <= z_in;
         neg_ff[0] <= neg_in;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_iter
      logic signed [W-1:0] dx;
      logic signed [W-1:0] dy;
      logic signed [W-1:0] step_ang;

      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      assign step_ang = signed'({{(W-32){1'b0}}, gcdb_pkg::atan_tab(i)});

      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[i+1] <= neg_ff[i];
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - step_ang;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + step_ang;
            end
         end
      end
   end

   assign sin_out = neg_ff[STEPS] ? 32'(-y_ff[STEPS]) : 32'(y_ff[STEPS]);
   assign cos_out = neg_ff[STEPS] ? 32'(-x_ff[STEPS]) : 32'(x_ff[STEPS]);

endmodule

### hw/rtl/gcdb_isqrt.sv
// ----------------------------------------------------------------------------
// gcdb_isqrt
// pipelined floor square root of a q60 value, one result bit per stage
// ----------------------------------------------------------------------------
module gcdb_isqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [60:0] val,
   output logic [30:0] root
);

   localparam int N = gcdb_pkg::SQRT_STEPS;

   logic [61:0] v_ff [0:N-1];
   logic [61:0] r_ff [0:N-1];

   for (genvar k = 0; k < N; k++) begin : g_bit
      localparam logic [61:0] BIT = 62'(1) << (60 - 2 * k);
      logic [61:0] v_cur;
      logic [61:0] r_cur;
      logic [61:0] trial;

      if (k == 0) begin : g_first
         assign v_cur = {1'b0, val};
         assign r_cur = '0;
      end else begin : g_next
         assign v_cur = v_ff[k-1];
         assign r_cur = r_ff[k-1];
      end

      assign trial = r_cur + BIT;

      always_ff @(posedge clock) begin
         if (en) begin
            if (v_cur >= trial) begin
               v_ff[k] <= v_cur - trial;
               r_ff[k] <= (r_cur >> 1) + BIT;
            end else begin
               v_ff[k] <= v_cur;
               r_ff[k] <= r_cur >> 1;
            end
         end
      end
   end

   assign root = r_ff[N-1][30:0];

endmodule

### hw/rtl/gcdb_atan2.sv
// ----------------------------------------------------------------------------
// gcdb_atan2
// pipelined cordic vectoring: half-plane turn and normalize stage, then one
// iteration per stage, binary-angle result
// ----------------------------------------------------------------------------
module gcdb_atan2 #(
   parameter int STEPS = 24
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [33:0] y_in,
   input  logic signed [33:0] x_in,
   output gcdb_pkg::bam_type  ang
);

   localparam int W = 36;

   logic signed [W-1:0] x_ff [0:STEPS];
   logic signed [W-1:0] y_ff [0:STEPS];
   logic [31:0]         z_ff [0:STEPS];
   logic                base_ff [0:STEPS];
   logic                zero_ff [0:STEPS];

   logic signed [33:0] xn;
   logic signed [33:0] yn;
   logic [33:0]        ay;
   logic [33:0]        mag;
   logic signed [W-1:0] xs;
   logic signed [W-1:0] ys;

   always_comb begin
      if (x_in < 0) begin
         xn = -x_in;
         yn = -y_in;
      end else begin
         xn = x_in;
         yn = y_in;
      end
      ay  = (yn < 0) ? unsigned'(-yn) : unsigned'(yn);
      mag = unsigned'(xn) | ay;
      xs  = W'(xn);
      ys  = W'(yn);
      // doubling until either magnitude reaches 2^29
      for (int j = 4; j >= 0; j--) begin
         if (mag < (34'd1 << (30 - (1 << j)))) begin
            mag = mag << (1 << j);
            xs  = xs <<< (1 << j);
            ys  = ys <<< (1 << j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= xs;
         y_ff[0]    <= ys;
         z_ff[0]    <= '0;
         base_ff[0] <= (x_in < 0);
         zero_ff[0] <= (x_in == 0) && (y_in == 0);
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_iter
      logic signed [W-1:0] dx;
      logic signed [W-1:0] dy;

      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (en) begin
            base_ff[i+1] <= base_ff[i];
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + gcdb_pkg::atan_tab(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - gcdb_pkg::atan_tab(i);
            end
         end
      end
   end

   assign ang = zero_ff[STEPS] ? '0 : ({base_ff[STEPS], 31'b0} + z_ff[STEPS]);

endmodule

### hw/rtl/great_circle_distance_bearing_unit.sv
// ----------------------------------------------------------------------------
// great_circle_distance_bearing_unit
// haversine distance in meters and initial bearing in hundredths of a degree
// between two points given in degrees times 1e7
//
//   channel  dir  handshake               payload
//   req      in   req_tvalid/req_tready   from_lat, from_lon, to_lat, to_lon
//   rsp      out  rsp_tvalid/rsp_tready   distance_m, bearing_cdeg
//
// one item per cycle while no result is held; the pipeline runs through the two
// cordic stage chains and the 31-stage square root
// reset clears the valid bits only, no clearing pass
// a held result stalls the whole pipeline in place, nothing is lost
// ----------------------------------------------------------------------------
module great_circle_distance_bearing_unit #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // from_lat[30:0], from_lon[62:31], to_lat[93:63], to_lon[125:94], zero pad
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // distance_m[24:0], bearing_cdeg[40:25], zero pad
   output logic [47:0]  rsp_tdata
);

   localparam int SC_LAT = CORDIC_STEPS + 1;
   localparam int LAT    = 2 * CORDIC_STEPS + 42;
   localparam int ID_DLY = 2 * SC_LAT + 4 + gcdb_pkg::SQRT_STEPS;

   localparam logic signed [64:0] A_ONE = 65'sd1 <<< 60;

   logic [LAT-1:0] valid_ff;
   logic           en;

   assign en         = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = valid_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAT-2:0], req_tvalid};
      end
   end

   // degrees to binary angle: multiply, then round and sign
   logic signed [31:0] deg [0:3];
   logic [31:0]        deg_mag [0:3];
   logic [62:0]        bam_prod_ff [0:3];
   logic               bam_neg_ff [0:3];
   logic [63:0]        bam_rnd [0:3];
   gcdb_pkg::bam_type  bam_ff [0:3];

   assign deg[0] = signed'({req_tdata[30], req_tdata[30:0]});
   assign deg[1] = signed'(req_tdata[62:31]);
   assign deg[2] = signed'({req_tdata[93], req_tdata[93:63]});
   assign deg[3] = signed'(req_tdata[125:94]);

   for (genvar k = 0; k < 4; k++) begin : g_bam
      assign deg_mag[k] = deg[k][31] ? unsigned'(-deg[k]) : unsigned'(deg[k]);
      assign bam_rnd[k] = {1'b0, bam_prod_ff[k]} + 64'd536870912;

      always_ff @(posedge clock) begin
         if (en) begin
            bam_prod_ff[k] <= deg_mag[k] * gcdb_pkg::DEG_TO_BAM;
            bam_neg_ff[k]  <= deg[k][31];
            bam_ff[k]      <= bam_neg_ff[k] ? (32'd0 - bam_rnd[k][61:30]) : bam_rnd[k][61:30];
         end
      end
   end

   // angle differences
   gcdb_pkg::bam_type dlat;
   gcdb_pkg::bam_type dlon;
   gcdb_pkg::bam_type ang_ff [0:4];
   logic              ident_ff;

   assign dlat = bam_ff[2] - bam_ff[0];
   assign dlon = bam_ff[3] - bam_ff[1];

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff[0] <= bam_ff[0];
         ang_ff[1] <= bam_ff[2];
         ang_ff[2] <= dlat >> 1;
         ang_ff[3] <= dlon >> 1;
         ang_ff[4] <= dlon;
         ident_ff  <= (dlon == 32'd0) && (bam_ff[0] == bam_ff[2]);
      end
   end

   gcdb_pkg::q30_type s1, c1, s2, c2, sh1, sh2, sdl, cdl;
   gcdb_pkg::q30_type ch1, ch2;

   gcdb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_lat1 (
      .clock(clock), .en(en), .ang(ang_ff[0]), .sin_out(s1), .cos_out(c1));
   gcdb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_lat2 (
      .clock(clock), .en(en), .ang(ang_ff[1]), .sin_out(s2), .cos_out(c2));
   gcdb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_hlat (
      .clock(clock), .en(en), .ang(ang_ff[2]), .sin_out(sh1), .cos_out(ch1));
   gcdb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_hlon (
      .clock(clock), .en(en), .ang(ang_ff[3]), .sin_out(sh2), .cos_out(ch2));
   gcdb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_dlon (
      .clock(clock), .en(en), .ang(ang_ff[4]), .sin_out(sdl), .cos_out(cdl));

   // product stages
   logic signed [63:0] cc_p_ff, shsq_p1_ff, by_p_ff, c1s2_p_ff, s1c2_p_ff;
   gcdb_pkg::q30_type  sh2_p1_ff, cdl_p1_ff;
   logic signed [63:0] t1_ff, t2_ff, shsq_p2_ff;
   gcdb_pkg::q30_type  by_p2_ff, c1s2_p2_ff, sh2_p2_ff;
   gcdb_pkg::q30_type  cc_w, s1c2_w, t1_w;
   logic signed [63:0] hp_ff, shsq_p3_ff;
   gcdb_pkg::q30_type  by_p3_ff;
   logic signed [32:0] bx_p3_ff;
   logic signed [64:0] a_sum;
   logic [60:0]        a_cl;
   logic [60:0]        a_ff, ma_ff;
   gcdb_pkg::q30_type  by_p4_ff;
   logic signed [32:0] bx_p4_ff;

   assign cc_w   = 32'(cc_p_ff >>> 30);
   assign s1c2_w = 32'(s1c2_p_ff >>> 30);
   assign t1_w   = 32'(t1_ff >>> 30);
   assign a_sum  = 65'(shsq_p3_ff) + 65'(hp_ff);

   always_comb begin
      if (a_sum < 0) begin
         a_cl = '0;
      end else if (a_sum > A_ONE) begin
         a_cl = 61'(A_ONE);
      end else begin
         a_cl = 61'(a_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cc_p_ff    <= c1 * c2;
         shsq_p1_ff <= sh1 * sh1;
         by_p_ff    <= sdl * c2;
         c1s2_p_ff  <= c1 * s2;
         s1c2_p_ff  <= s1 * c2;
         sh2_p1_ff  <= sh2;
         cdl_p1_ff  <= cdl;

         t1_ff      <= cc_w * sh2_p1_ff;
         t2_ff      <= s1c2_w * cdl_p1_ff;
         shsq_p2_ff <= shsq_p1_ff;
         by_p2_ff   <= 32'(by_p_ff >>> 30);
         c1s2_p2_ff <= 32'(c1s2_p_ff >>> 30);
         sh2_p2_ff  <= sh2_p1_ff;

         hp_ff      <= t1_w * sh2_p2_ff;
         bx_p3_ff   <= 33'(c1s2_p2_ff) - 33'(t2_ff >>> 30);
         shsq_p3_ff <= shsq_p2_ff;
         by_p3_ff   <= by_p2_ff;

         a_ff       <= a_cl;
         ma_ff      <= 61'(A_ONE) - a_cl;
         by_p4_ff   <= by_p3_ff;
         bx_p4_ff   <= bx_p3_ff;
      end
   end

   // square roots, bearing operands wait alongside
   logic [30:0]        root_a, root_ma;
   gcdb_pkg::q30_type  by_d;
   logic signed [32:0] bx_d;

   gcdb_isqrt u_sqrt_a  (.clock(clock), .en(en), .val(a_ff),  .root(root_a));
   gcdb_isqrt u_sqrt_ma (.clock(clock), .en(en), .val(ma_ff), .root(root_ma));

   gcdb_delay #(.WIDTH(65), .DEPTH(gcdb_pkg::SQRT_STEPS)) u_dly_bear (
      .clock(clock), .en(en), .d({by_p4_ff, bx_p4_ff}), .q({by_d, bx_d}));

   gcdb_pkg::bam_type g_ang, b_ang;

   gcdb_atan2 #(.STEPS(CORDIC_STEPS)) u_at_dist (
      .clock(clock), .en(en),
      .y_in(signed'({3'b000, root_a})), .x_in(signed'({3'b000, root_ma})),
      .ang(g_ang));

   gcdb_atan2 #(.STEPS(CORDIC_STEPS)) u_at_bear (
      .clock(clock), .en(en), .y_in(34'(by_d)), .x_in(34'(bx_d)), .ang(b_ang));

   logic ident_d;

   gcdb_delay #(.WIDTH(1), .DEPTH(ID_DLY)) u_dly_ident (
      .clock(clock), .en(en), .d(ident_ff), .q(ident_d));

   // scaling to meters and hundredths of a degree
   logic [30:0] g_cl;
   logic [48:0] pd_hi_ff;
   logic [46:0] pd_lo_ff;
   logic [47:0] pb_ff;
   logic        ident_m1_ff;
   logic [64:0] dsum;
   logic [48:0] cdsum;
   logic [16:0] cd;
   logic [24:0] dist_ff;
   logic [15:0] bearing_ff;

   always_comb begin
      if (g_ang[31]) begin
         g_cl = '0;
      end else if (g_ang > 32'h40000000) begin
         g_cl = 31'h40000000;
      end else begin
         g_cl = g_ang[30:0];
      end
   end

   assign dsum  = {pd_hi_ff, 16'b0} + 65'(pd_lo_ff);
   assign cdsum = 49'(pb_ff) + 49'h0_8000_0000;
   assign cd    = cdsum[48:32];

   always_ff @(posedge clock) begin
      if (en) begin
         pd_hi_ff    <= g_cl * gcdb_pkg::DIST_HI;
         pd_lo_ff    <= g_cl * gcdb_pkg::DIST_LO;
         pb_ff       <= b_ang * gcdb_pkg::CDEG_TURN;
         ident_m1_ff <= ident_d;

         dist_ff <= dsum[63:39];
         if (ident_m1_ff || (cd >= 17'(gcdb_pkg::CDEG_TURN))) begin
            bearing_ff <= '0;
         end else begin
            bearing_ff <= cd[15:0];
         end
      end
   end

   assign rsp_tdata = {7'b0, bearing_ff, dist_ff};

`ifndef NO_ASSERTIONS
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(valid_ff))
      else $error("pipeline valid bits moved during a stall");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[0])
      else $error("accepted item did not enter the pipeline");

   a_bearing_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (bearing_ff < 16'd36000))
      else $error("bearing out of range");

   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (dist_ff <= 25'd20015087))
      else $error("distance out of range");
`endif

endmodule
